[hw/rtl/great_circle_distance_defines.svh]
// Assertion macros for the great-circle distance block.
// Used by modules that declare clk and rst; no other dependencies.
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication
`define GCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gcd_pkg.sv]
// Shared types, fixed-point constants and arctangent table for the
// great-circle distance pipeline. No dependencies.
package gcd_pkg;

  localparam int XY_W      = 34;
  localparam int Z_W       = 34;
  localparam int ANG_W     = 31;
  localparam int ROOT_W    = 31;
  localparam int ISQ_STEPS = 31;
  localparam int DIST_W    = 30;
  localparam int RAD_W     = 24;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  zang_t;

  localparam logic [33:0] PI_Q30      = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam xy_t         GAIN_Q30    = 34'sd652032874;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [RAD_W-1:0] RESET_RADIUS = 24'd6371000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  function automatic logic [31:0] mag32(input xy_t v);
    xy_t a;
    a = (v < 0) ? -v : v;
    return a[31:0];
  endfunction

endpackage

[hw/rtl/gcd_cordic_rot.sv]
// Pipelined rotation CORDIC, one register stage per step: cos and sin of
// an angle in [0, pi/2] Q30. Depends on gcd_pkg.
module gcd_cordic_rot #(
  parameter int STEPS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [gcd_pkg::ANG_W-1:0] in_z,
  input  logic                     in_tag,
  output logic                     out_vld,
  output gcd_pkg::xy_t             out_cos,
  output gcd_pkg::xy_t             out_sin,
  output logic                     out_tag
);

  gcd_pkg::xy_t   x   [STEPS+1];
  gcd_pkg::xy_t   y   [STEPS+1];
  gcd_pkg::zang_t z   [STEPS+1];
  logic           vld [STEPS+1];
  logic           tag [STEPS+1];

  assign x[0]   = gcd_pkg::GAIN_Q30;
  assign y[0]   = '0;
  assign z[0]   = gcd_pkg::zang_t'({{(gcd_pkg::Z_W-gcd_pkg::ANG_W){1'b0}}, in_z});
  assign vld[0] = in_vld;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam gcd_pkg::zang_t ATAN_I =
      gcd_pkg::zang_t'({{(gcd_pkg::Z_W-32){1'b0}}, gcd_pkg::ATAN_Q30[i]});
    gcd_pkg::xy_t dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[i+1] <= tag[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ATAN_I;
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ATAN_I;
        end
      end
    end
  end

  assign out_vld = vld[STEPS];
  assign out_cos = x[STEPS];
  assign out_sin = y[STEPS];
  assign out_tag = tag[STEPS];

endmodule

[hw/rtl/gcd_isqrt.sv]
// Pipelined bit-serial square root, one result bit per stage:
// floor(sqrt(a * 2^30)) for a in Q30. Depends on gcd_pkg.
module gcd_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [gcd_pkg::ROOT_W-1:0] in_a,
  output logic                      out_vld,
  output logic [gcd_pkg::ROOT_W-1:0] out_root
);

  localparam int N = gcd_pkg::ISQ_STEPS;

  logic [34:0]               rem  [N];
  logic [61:0]               val  [N];
  logic [gcd_pkg::ROOT_W-1:0] root [N+1];
  logic                      vld  [N+1];

  assign rem[0]  = '0;
  assign val[0]  = {1'b0, in_a, 30'b0};
  assign root[0] = '0;
  assign vld[0]  = in_vld;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [34:0] t, trial;
    logic        ge;
    assign t     = {rem[k][32:0], val[k][61:60]};
    assign trial = {2'b00, root[k], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[k+1] <= {root[k][gcd_pkg::ROOT_W-2:0], ge};
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (t - trial) : t;
          val[k+1] <= {val[k][59:0], 2'b00};
        end
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_root = root[N];

endmodule

[hw/rtl/gcd_cordic_vec.sv]
// Pipelined vectoring CORDIC, one register stage per step: atan2(y, x)
// in Q30 clamped to [0, pi/2]. Depends on gcd_pkg.
module gcd_cordic_vec #(
  parameter int STEPS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [gcd_pkg::ROOT_W-1:0] in_x,
  input  logic [gcd_pkg::ROOT_W-1:0] in_y,
  output logic                      out_vld,
  output logic [gcd_pkg::ANG_W-1:0]  out_ang
);

  gcd_pkg::xy_t   x   [STEPS+1];
  gcd_pkg::xy_t   y   [STEPS+1];
  gcd_pkg::zang_t z   [STEPS+1];
  logic           vld [STEPS+1];

  assign x[0]   = gcd_pkg::xy_t'({{(gcd_pkg::XY_W-gcd_pkg::ROOT_W){1'b0}}, in_x});
  assign y[0]   = gcd_pkg::xy_t'({{(gcd_pkg::XY_W-gcd_pkg::ROOT_W){1'b0}}, in_y});
  assign z[0]   = '0;
  assign vld[0] = in_vld;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam gcd_pkg::zang_t ATAN_I =
      gcd_pkg::zang_t'({{(gcd_pkg::Z_W-32){1'b0}}, gcd_pkg::ATAN_Q30[i]});
    gcd_pkg::xy_t dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ATAN_I;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ATAN_I;
        end
      end
    end
  end

  always_comb begin
    if (z[STEPS] < 0) begin
      out_ang = '0;
    end else if (z[STEPS] > gcd_pkg::zang_t'(gcd_pkg::HALF_PI_Q30)) begin
      out_ang = gcd_pkg::HALF_PI_Q30[gcd_pkg::ANG_W-1:0];
    end else begin
      out_ang = z[STEPS][gcd_pkg::ANG_W-1:0];
    end
  end

  assign out_vld = vld[STEPS];

endmodule

[hw/rtl/great_circle_distance.sv]
// Haversine great-circle distance: top level of the pipeline.
// Uses gcd_pkg, gcd_cordic_rot, gcd_isqrt, gcd_cordic_vec and the defines header.
//
// Takes one word per clock: two positions in degrees * 2^24, and returns
// the distance in metres * 16 through the two CORDIC pipelines and the
// 31-stage square roots. All stages advance together; when the output
// register holds a word that is not taken, the whole pipe holds and
// s_tready drops. The user must write the radius register through cfg_*
// only while no word is in flight; the block does not enforce this.
`include "great_circle_distance_defines.svh"

module great_circle_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // lat_a[31:0], lon_a[64:32], lat_b[96:65], lon_b[129:97]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // distance_q4[29:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);

  logic                        en;
  logic [gcd_pkg::RAD_W-1:0]   radius;

  logic signed [31:0] lat_a, lat_b;
  logic signed [32:0] lon_a, lon_b;
  logic signed [32:0] dlat;
  logic signed [33:0] dlon;
  logic [32:0]        dlat_m;
  logic [33:0]        dlon_m;
  logic [31:0]        lat_a_m, lat_b_m;

  logic [33:0] mg [4];
  logic        vld_a;
  logic [43:0] pl [4];
  logic [43:0] ph [4];
  logic        vld_b;
  logic [61:0] sum_c [4];
  logic [33:0] rad [4];
  logic        vld_c;
  logic [31:0] r_d [4];
  logic        vld_d;
  logic [30:0] z_e [4];
  logic        neg_e [4];
  logic        vld_e;

  logic         vld_r;
  gcd_pkg::xy_t sin_lat, sin_lon, cos_a, cos_b;
  logic         neg_a, neg_b;
  gcd_pkg::xy_t cos_as, cos_bs;

  logic [31:0] m_sl, m_so, m_ca, m_cb;
  logic [63:0] sq_lat, sq_lon, cp;
  logic        cneg1, vld_p1;
  logic [63:0] t_sl, t_so, t_cp;
  logic [30:0] s2lat, s2lon;
  logic [31:0] cm;
  logic        tneg2, vld_p2;
  logic [63:0] tp;
  logic [30:0] s2lat3;
  logic        tneg3, vld_p3;
  logic [63:0] t_tp;
  logic signed [33:0] term;
  logic [30:0] s2lat4;
  logic        vld_p4;
  logic signed [33:0] hsum;
  logic [30:0] a_hav;
  logic        vld_p5;

  logic [gcd_pkg::ROOT_W-1:0] root_a, root_b;
  logic                       vld_sq;
  logic [gcd_pkg::ANG_W-1:0]  ang;
  logic                       vld_v;
  logic [55:0]                prod;
  logic                       vld_f;
  logic [56:0]                dsum;
  logic [gcd_pkg::DIST_W-1:0] distance;
  logic                       vld_g;

  assign en        = !vld_g || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld_g;
  assign m_tdata   = {2'b00, distance};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcd_pkg::RESET_RADIUS;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  // input: differences and magnitudes
  assign lat_a   = s_tdata[31:0];
  assign lon_a   = s_tdata[64:32];
  assign lat_b   = s_tdata[96:65];
  assign lon_b   = s_tdata[129:97];
  assign dlat    = 33'(lat_b) - 33'(lat_a);
  assign dlon    = 34'(lon_b) - 34'(lon_a);
  assign dlat_m  = dlat[32] ? 33'(-dlat) : 33'(dlat);
  assign dlon_m  = dlon[33] ? 34'(-dlon) : 34'(dlon);
  assign lat_a_m = lat_a[31] ? 32'(-lat_a) : 32'(lat_a);
  assign lat_b_m = lat_b[31] ? 32'(-lat_b) : 32'(lat_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      vld_e <= 1'b0;
    end else if (en) begin
      vld_a <= s_tvalid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
      vld_e <= vld_d;
    end
  end

  // lanes: 0 dlat (half), 1 dlon (half), 2 lat_a, 3 lat_b
  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam bit HALF = (j < 2);
    assign sum_c[j] = {1'b0, ph[j], 17'b0} + 62'(pl[j])
                    + (HALF ? 62'(1) << 26 : 62'(1) << 25);

    always_ff @(posedge clk) begin
      if (en) begin
        pl[j]  <= 44'(mg[j][16:0]) * 44'(gcd_pkg::DEG2RAD_Q32);
        ph[j]  <= 44'(mg[j][33:17]) * 44'(gcd_pkg::DEG2RAD_Q32);
        rad[j] <= HALF ? 34'(sum_c[j] >> 27) : 34'(sum_c[j] >> 26);
        if (HALF) begin
          r_d[j] <= (rad[j] >= gcd_pkg::PI_Q30) ? 32'(rad[j] - gcd_pkg::PI_Q30)
                                                : rad[j][31:0];
        end else begin
          r_d[j] <= (rad[j] > gcd_pkg::PI_Q30) ? 32'(gcd_pkg::TWO_PI_Q30 - rad[j])
                                               : rad[j][31:0];
        end
        if (34'(r_d[j]) > gcd_pkg::HALF_PI_Q30) begin
          z_e[j]   <= 31'(gcd_pkg::PI_Q30 - 34'(r_d[j]));
          neg_e[j] <= !HALF;
        end else begin
          z_e[j]   <= r_d[j][30:0];
          neg_e[j] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mg[0] <= {1'b0, dlat_m};
      mg[1] <= dlon_m;
      mg[2] <= {2'b00, lat_a_m};
      mg[3] <= {2'b00, lat_b_m};
    end
  end

  gcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlat (
    .clk, .rst, .en, .in_vld(vld_e), .in_z(z_e[0]), .in_tag(neg_e[0]),
    .out_vld(vld_r), .out_cos(), .out_sin(sin_lat), .out_tag()
  );
  gcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_dlon (
    .clk, .rst, .en, .in_vld(vld_e), .in_z(z_e[1]), .in_tag(neg_e[1]),
    .out_vld(), .out_cos(), .out_sin(sin_lon), .out_tag()
  );
  gcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat_a (
    .clk, .rst, .en, .in_vld(vld_e), .in_z(z_e[2]), .in_tag(neg_e[2]),
    .out_vld(), .out_cos(cos_a), .out_sin(), .out_tag(neg_a)
  );
  gcd_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot_lat_b (
    .clk, .rst, .en, .in_vld(vld_e), .in_z(z_e[3]), .in_tag(neg_e[3]),
    .out_vld(), .out_cos(cos_b), .out_sin(), .out_tag(neg_b)
  );

  assign cos_as = neg_a ? -cos_a : cos_a;
  assign cos_bs = neg_b ? -cos_b : cos_b;
  assign m_sl   = gcd_pkg::mag32(sin_lat);
  assign m_so   = gcd_pkg::mag32(sin_lon);
  assign m_ca   = gcd_pkg::mag32(cos_as);
  assign m_cb   = gcd_pkg::mag32(cos_bs);

  // haversine term
  assign t_sl = sq_lat + (64'(1) << 29);
  assign t_so = sq_lon + (64'(1) << 29);
  assign t_cp = cp + (64'(1) << 29);
  assign t_tp = tp + (64'(1) << 29);
  assign hsum = 34'(s2lat4) + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p1 <= 1'b0;
      vld_p2 <= 1'b0;
      vld_p3 <= 1'b0;
      vld_p4 <= 1'b0;
      vld_p5 <= 1'b0;
      vld_f  <= 1'b0;
      vld_g  <= 1'b0;
    end else if (en) begin
      vld_p1 <= vld_r;
      vld_p2 <= vld_p1;
      vld_p3 <= vld_p2;
      vld_p4 <= vld_p3;
      vld_p5 <= vld_p4;
      vld_f  <= vld_v;
      vld_g  <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat <= 64'(m_sl) * 64'(m_sl);
      sq_lon <= 64'(m_so) * 64'(m_so);
      cp     <= 64'(m_ca) * 64'(m_cb);
      cneg1  <= cos_as[gcd_pkg::XY_W-1] ^ cos_bs[gcd_pkg::XY_W-1];

      s2lat <= (t_sl[63:30] > 34'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : t_sl[60:30];
      s2lon <= (t_so[63:30] > 34'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : t_so[60:30];
      cm    <= t_cp[61:30];
      tneg2 <= cneg1 && (t_cp[63:30] != '0);

      tp     <= 64'(cm) * 64'(s2lon);
      tneg3  <= tneg2 && (cm != '0);
      s2lat3 <= s2lat;

      s2lat4 <= s2lat3;

      if (hsum < 0) begin
        a_hav <= '0;
      end else if (hsum > 34'(gcd_pkg::ONE_Q30)) begin
        a_hav <= gcd_pkg::ONE_Q30;
      end else begin
        a_hav <= hsum[30:0];
      end

      prod <= 56'(radius) * 56'({ang, 1'b0});

      if (dsum[56:26] > 31'(gcd_pkg::DIST_MAX)) begin
        distance <= gcd_pkg::DIST_MAX;
      end else begin
        distance <= dsum[55:26];
      end
    end
  end

  // sign applied to the rounded magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      term <= (tneg3 && (t_tp[63:30] != '0)) ? -34'(t_tp[63:30]) : 34'(t_tp[63:30]);
    end
  end

  gcd_isqrt u_sqrt_a (
    .clk, .rst, .en, .in_vld(vld_p5), .in_a(a_hav),
    .out_vld(vld_sq), .out_root(root_a)
  );
  gcd_isqrt u_sqrt_b (
    .clk, .rst, .en, .in_vld(vld_p5), .in_a(gcd_pkg::ONE_Q30 - a_hav),
    .out_vld(), .out_root(root_b)
  );

  gcd_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk, .rst, .en, .in_vld(vld_sq), .in_x(root_b), .in_y(root_a),
    .out_vld(vld_v), .out_ang(ang)
  );

  assign dsum = 57'(prod) + (57'(1) << 25);

  `GCD_ASSERT_IMPL(a_hav_range, vld_p5, a_hav <= gcd_pkg::ONE_Q30, "haversine term above one")
  `GCD_ASSERT_IMPL(a_root_range, vld_sq, root_a <= gcd_pkg::ONE_Q30 && root_b <= gcd_pkg::ONE_Q30, "root out of range")
  `GCD_ASSERT_IMPL(a_ang_range, vld_v, 34'(ang) <= gcd_pkg::HALF_PI_Q30, "angle above pi/2")
  `GCD_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_a) && $stable(vld_p5) && $stable(vld_f), "pipe moved while stalled")

endmodule
